@@ rtl/core/scpp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package scpp_pkg;

  localparam int ROW_W = 32;
  localparam int COL_W = 32;
  localparam int VAL_W = 16;
  localparam int IMG_W = 24;
  localparam int POS_W = 3;

  // Command fields are sized for the largest supported geometry (64 x 64).
  localparam int CMD_SLOT_W = 12;
  localparam int CMD_PART_W = 6;

  localparam int QUEUE_DEPTH = 2;

  localparam logic KIND_ENTRY    = 1'b0;
  localparam logic KIND_END_TILE = 1'b1;

  typedef struct packed {
    logic                  emit;   // sweep out the held image first
    logic                  flush;  // end of tile: no entry to write afterwards
    logic [CMD_SLOT_W-1:0] slot;
    logic [CMD_PART_W-1:0] part;
    logic [ROW_W-1:0]      row;
    logic [VAL_W-1:0]      value;
    logic [COL_W-1:0]      col;
    logic [IMG_W-1:0]      img;    // number of the image being swept
  } scpp_cmd_t;

  typedef enum logic [1:0] {
    BACK_IDLE,
    BACK_EMIT,
    BACK_FINISH
  } back_state_e;

endpackage
`default_nettype wire

@@ rtl/core/scpp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface scpp_in_if import scpp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [ROW_W-1:0] entry_row;
  logic [COL_W-1:0] entry_column;
  logic [VAL_W-1:0] entry_value;

  modport source (output valid, kind, entry_row, entry_column, entry_value, input ready);
  modport sink   (input valid, kind, entry_row, entry_column, entry_value, output ready);
endinterface

interface scpp_out_if import scpp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IMG_W-1:0] image_number;
  logic [POS_W-1:0] partition_slot;
  logic [POS_W-1:0] lane;
  logic [ROW_W-1:0] slot_row;
  logic [VAL_W-1:0] slot_value;
  logic [COL_W-1:0] slot_column;
  logic             column_valid;
  logic             last;

  modport source (output valid, image_number, partition_slot, lane, slot_row, slot_value,
                  slot_column, column_valid, last, input ready);
  modport sink   (input valid, image_number, partition_slot, lane, slot_row, slot_value,
                  slot_column, column_valid, last, output ready);
endinterface

interface scpp_cfg_if ();
  logic valid;
  logic ready;
  logic force_unit_values;

  modport source (output valid, force_unit_values, input ready);
  modport sink   (input valid, force_unit_values, output ready);
endinterface
`default_nettype wire

@@ rtl/core/sparse_column_partition_packer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Dir | Transaction
// ---------+-----+---------------------------------------------------------------
// in_ch    | in  | one entry (kind, entry_row, entry_column, entry_value) or end of tile
// out_ch   | out | one lane of an emitted row image, partition slot then lane order
// cfg_ch   | in  | write of force_unit_values; always ready
//
// An entry that does not close an image is classified by the front, queued, and
// written into the slot store by the back, one per cycle while the back is idle.
// A sweep takes the command, reads one slot per cycle unless out_ch stalls, via the
// read stage and output register, then clears the store and writes a spilling entry.
// Reset clears all control state and the valid bits at once; there is no sweep.
// out_ch stalls hold the sweep; in_ch stalls only when the two-entry queue is full.
module sparse_column_partition_packer import scpp_pkg::*; #(
  parameter int LANES      = 8,
  parameter int PARTITIONS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  scpp_in_if.sink    in_ch,
  scpp_out_if.source out_ch,
  scpp_cfg_if.sink   cfg_ch
);

  // mode register, read at emission time
  logic force_q;

  scpp_cmd_t front_cmd, back_cmd;
  logic      front_valid, front_ready;
  logic      back_valid, back_ready;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      force_q <= 1'b1;
    end else if (cfg_ch.valid) begin
      force_q <= cfg_ch.force_unit_values;
    end
  end

  // front: owns the packing position and classifies each item into a command
  scpp_front #(
    .LANES      (LANES),
    .PARTITIONS (PARTITIONS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .cmd_o       (front_cmd),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready)
  );

  scpp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (front_cmd),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_o        (back_cmd),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready)
  );

  // back: slot store, image sweep and output register
  scpp_back #(
    .LANES      (LANES),
    .PARTITIONS (PARTITIONS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (back_cmd),
    .cmd_valid_i  (back_valid),
    .cmd_ready_o  (back_ready),
    .force_unit_i (force_q),
    .out_ch       (out_ch)
  );

  // the final transaction of an image sits at the last lane of the last partition
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.last |->
      out_ch.lane == POS_W'(LANES-1) && out_ch.partition_slot == POS_W'(PARTITIONS-1))
    else $error("last flag off the final slot");

  // an image streams without gaps once started
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.ready && !out_ch.last |=> out_ch.valid)
    else $error("gap inside an image");

  // a new image starts at the first lane of the first partition
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.ready && out_ch.last |=>
      !out_ch.valid || (out_ch.lane == '0 && out_ch.partition_slot == '0))
    else $error("image does not start at slot zero");

endmodule
`default_nettype wire

@@ rtl/core/scpp_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module scpp_front import scpp_pkg::*; #(
  parameter int LANES      = 8,
  parameter int PARTITIONS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  scpp_in_if.sink    in_ch,
  output scpp_cmd_t  cmd_o,
  output logic       cmd_valid_o,
  input  logic       cmd_ready_i
);

  localparam int SLOTS = LANES * PARTITIONS;
  localparam int LW    = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int PW    = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [COL_W-1:0] cur_col_q, cur_col_d;
  logic [LW-1:0]    lane_q, lane_d;
  logic [PW-1:0]    part_q, part_d;
  logic             started_q, started_d;
  logic [IMG_W-1:0] img_q, img_d;

  logic          accept;
  logic          advance;
  logic          wrap;
  logic [LW-1:0] lane_eff;
  logic [PW-1:0] part_eff;
  logic [PW:0]   part_inc;
  logic [LW:0]   lane_next;
  logic [SW-1:0] slot;

  assign in_ch.ready = cmd_ready_i;
  assign cmd_valid_o = in_ch.valid;
  assign accept      = in_ch.valid && cmd_ready_i;

  always_comb begin
    // open a new partition on a column change mid-partition or on a full one
    advance   = started_q && ((lane_q != '0 && in_ch.entry_column != cur_col_q) ||
                              lane_q == '0);
    lane_eff  = advance ? '0 : lane_q;
    part_inc  = {1'b0, part_q} + (PW+1)'(1);
    wrap      = advance && (part_inc >= (PW+1)'(PARTITIONS));
    part_eff  = wrap ? '0 : (advance ? part_inc[PW-1:0] : part_q);
    slot      = SW'(part_eff) * SW'(LANES) + SW'(lane_eff);
    lane_next = {1'b0, lane_eff} + (LW+1)'(1);

    cmd_o.flush = (in_ch.kind == KIND_END_TILE);
    cmd_o.emit  = (in_ch.kind == KIND_END_TILE) || wrap;
    cmd_o.slot  = CMD_SLOT_W'(slot);
    cmd_o.part  = CMD_PART_W'(part_eff);
    cmd_o.row   = in_ch.entry_row;
    cmd_o.value = in_ch.entry_value;
    cmd_o.col   = in_ch.entry_column;
    cmd_o.img   = img_q;

    cur_col_d = cur_col_q;
    lane_d    = lane_q;
    part_d    = part_q;
    started_d = started_q;
    img_d     = img_q;
    if (accept) begin
      if (in_ch.kind == KIND_END_TILE) begin
        cur_col_d = '0;
        lane_d    = '0;
        part_d    = '0;
        started_d = 1'b0;
        img_d     = '0;
      end else begin
        cur_col_d = in_ch.entry_column;
        lane_d    = (lane_next == (LW+1)'(LANES)) ? '0 : lane_next[LW-1:0];
        part_d    = part_eff;
        started_d = 1'b1;
        img_d     = wrap ? img_q + IMG_W'(1) : img_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q <= '0;
      lane_q    <= '0;
      part_q    <= '0;
      started_q <= 1'b0;
      img_q     <= '0;
    end else begin
      cur_col_q <= cur_col_d;
      lane_q    <= lane_d;
      part_q    <= part_d;
      started_q <= started_d;
      img_q     <= img_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/scpp_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module scpp_queue import scpp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  scpp_cmd_t push_i,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  output scpp_cmd_t pop_o,
  output logic      pop_valid_o,
  input  logic      pop_ready_i
);

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  scpp_cmd_t     entry_q [QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QW:0]   cnt_q, cnt_d;
  logic          push, pop;

  assign push_ready_o = (cnt_q != (QW+1)'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_o        = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + QW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + QW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + (QW+1)'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - (QW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/scpp_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module scpp_back import scpp_pkg::*; #(
  parameter int LANES      = 8,
  parameter int PARTITIONS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  scpp_cmd_t  cmd_i,
  input  logic       cmd_valid_i,
  output logic       cmd_ready_o,
  input  logic       force_unit_i,
  scpp_out_if.source out_ch
);

  localparam int SLOTS = LANES * PARTITIONS;
  localparam int LW    = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int PW    = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  back_state_e state_q, state_d;

  // slot stores; an entry whose valid bit is clear reads as zero
  logic [ROW_W-1:0] row_mem [SLOTS];
  logic [VAL_W-1:0] val_mem [SLOTS];
  logic [COL_W-1:0] col_mem [PARTITIONS];
  logic [SLOTS-1:0]      slot_vld_q, slot_vld_d;
  logic [PARTITIONS-1:0] col_vld_q, col_vld_d;

  // sweep counters
  logic [SW-1:0] idx_q, idx_d;
  logic [LW-1:0] e_lane_q, e_lane_d;
  logic [PW-1:0] e_part_q, e_part_d;

  // read stage
  logic             rd_vld_q, rd_vld_d;
  logic [ROW_W-1:0] rd_row_q;
  logic [VAL_W-1:0] rd_val_q;
  logic [COL_W-1:0] rd_col_q;
  logic             rd_hit_q, rd_colv_q, rd_last_q;
  logic [IMG_W-1:0] rd_img_q;
  logic [LW-1:0]    rd_lane_q;
  logic [PW-1:0]    rd_part_q;

  // output register
  logic             out_vld_q, out_vld_d;
  logic [IMG_W-1:0] out_img_q;
  logic [POS_W-1:0] out_part_q, out_lane_q;
  logic [ROW_W-1:0] out_row_q;
  logic [VAL_W-1:0] out_val_q;
  logic [COL_W-1:0] out_col_q;
  logic             out_colv_q, out_last_q;

  logic          out_free, rd_adv, issue, last_slot, mem_wr;
  logic [SW-1:0] wr_slot;
  logic [PW-1:0] wr_part;

  assign out_free  = !out_vld_q || out_ch.ready;
  assign rd_adv    = rd_vld_q && out_free;
  assign issue     = (state_q == BACK_EMIT) && (!rd_vld_q || rd_adv);
  assign last_slot = (idx_q == SW'(SLOTS-1));
  assign wr_slot   = cmd_i.slot[SW-1:0];
  assign wr_part   = cmd_i.part[PW-1:0];

  always_comb begin
    state_d     = state_q;
    mem_wr      = 1'b0;
    cmd_ready_o = 1'b0;
    idx_d       = idx_q;
    e_lane_d    = e_lane_q;
    e_part_d    = e_part_q;
    slot_vld_d  = slot_vld_q;
    col_vld_d   = col_vld_q;

    case (state_q)
      BACK_IDLE: begin
        idx_d    = '0;
        e_lane_d = '0;
        e_part_d = '0;
        if (cmd_valid_i) begin
          if (cmd_i.emit) begin
            state_d = BACK_EMIT;
          end else begin
            mem_wr      = 1'b1;
            cmd_ready_o = 1'b1;
          end
        end
      end
      BACK_EMIT: begin
        if (issue) begin
          idx_d = idx_q + SW'(1);
          if (e_lane_q == LW'(LANES-1)) begin
            e_lane_d = '0;
            e_part_d = e_part_q + PW'(1);
          end else begin
            e_lane_d = e_lane_q + LW'(1);
          end
          if (last_slot) begin
            state_d = BACK_FINISH;
          end
        end
      end
      BACK_FINISH: begin
        // all slots have already been read out of the store, so the image can be dropped
        slot_vld_d  = '0;
        col_vld_d   = '0;
        mem_wr      = !cmd_i.flush;
        cmd_ready_o = 1'b1;
        state_d     = BACK_IDLE;
      end
      default: begin
        state_d = BACK_IDLE;
      end
    endcase

    if (mem_wr) begin
      slot_vld_d[wr_slot] = 1'b1;
      col_vld_d[wr_part]  = 1'b1;
    end

    rd_vld_d  = issue ? 1'b1 : (rd_adv ? 1'b0 : rd_vld_q);
    out_vld_d = rd_adv ? 1'b1 : (out_ch.ready ? 1'b0 : out_vld_q);
  end

  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      row_mem[wr_slot] <= cmd_i.row;
      val_mem[wr_slot] <= cmd_i.value;
      col_mem[wr_part] <= cmd_i.col;
    end
    if (issue) begin
      rd_row_q  <= row_mem[idx_q];
      rd_val_q  <= val_mem[idx_q];
      rd_col_q  <= col_mem[e_part_q];
      rd_hit_q  <= slot_vld_q[idx_q];
      rd_colv_q <= col_vld_q[e_part_q];
      rd_img_q  <= cmd_i.img;
      rd_lane_q <= e_lane_q;
      rd_part_q <= e_part_q;
      rd_last_q <= last_slot;
    end
    if (rd_adv) begin
      out_img_q  <= rd_img_q;
      out_part_q <= POS_W'(rd_part_q);
      out_lane_q <= POS_W'(rd_lane_q);
      out_row_q  <= rd_hit_q ? rd_row_q : '0;
      if (!rd_hit_q) begin
        out_val_q <= '0;
      end else if (force_unit_i) begin
        out_val_q <= VAL_W'(rd_row_q != '0);
      end else begin
        out_val_q <= rd_val_q;
      end
      out_col_q  <= rd_colv_q ? rd_col_q : '0;
      out_colv_q <= rd_colv_q && (rd_col_q != '0);
      out_last_q <= rd_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BACK_IDLE;
      idx_q      <= '0;
      e_lane_q   <= '0;
      e_part_q   <= '0;
      slot_vld_q <= '0;
      col_vld_q  <= '0;
      rd_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      e_lane_q   <= e_lane_d;
      e_part_q   <= e_part_d;
      slot_vld_q <= slot_vld_d;
      col_vld_q  <= col_vld_d;
      rd_vld_q   <= rd_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  assign out_ch.valid          = out_vld_q;
  assign out_ch.image_number   = out_img_q;
  assign out_ch.partition_slot = out_part_q;
  assign out_ch.lane           = out_lane_q;
  assign out_ch.slot_row       = out_row_q;
  assign out_ch.slot_value     = out_val_q;
  assign out_ch.slot_column    = out_col_q;
  assign out_ch.column_valid   = out_colv_q;
  assign out_ch.last           = out_last_q;

endmodule
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import scpp_pkg::*;

  localparam int LANES         = 8;
  localparam int PARTS         = 8;
  localparam int SLOTS         = LANES * PARTS;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 10;
  localparam int unsigned CYCLE_LIMIT = 1_500_000;

  // One input transaction.
  typedef struct packed {
    logic             kind;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [VAL_W-1:0] value;
  } entry_t;

  // One lane of an emitted row image.
  typedef struct packed {
    logic [IMG_W-1:0] img;
    logic [POS_W-1:0] part;
    logic [POS_W-1:0] lane;
    logic [ROW_W-1:0] row;
    logic [VAL_W-1:0] value;
    logic [COL_W-1:0] col;
    logic             col_ok;
    logic             is_last;
  } lane_t;

  logic clk_i;
  logic rst_ni;

  scpp_in_if  in_ch ();
  scpp_out_if out_ch ();
  scpp_cfg_if cfg_ch ();

  sparse_column_partition_packer #(
    .LANES      (LANES),
    .PARTITIONS (PARTS)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Packer model: mirrors the block's packing state and builds the lane
  // transactions of every image that an accepted item sweeps out.
  // ---------------------------------------------------------------------------
  logic [COL_W-1:0] m_column;
  int unsigned      m_lane;
  int unsigned      m_part;
  bit               m_started;
  logic [IMG_W-1:0] m_image;
  logic [ROW_W-1:0] m_rows   [SLOTS];
  logic [VAL_W-1:0] m_values [SLOTS];
  logic [COL_W-1:0] m_columns[PARTS];
  bit               m_unit_mode;

  lane_t  lanes_due[$];      // expected lane transactions, oldest first
  entry_t items_to_send[$];  // filled by the sequencer, drained by the driver

  int unsigned mismatches;
  int unsigned items_queued;
  int unsigned items_sent;
  int unsigned tiles_sent;
  int unsigned lanes_seen;
  int unsigned images_due;
  int unsigned in_stall_cycles;
  int unsigned mode_writes[2];
  int unsigned cycles = 0;

  bit calm;      // last stretch: no idling on either side
  bit hold_arm;  // asks for the one long receiver hold-off

  task automatic model_clear_stores();
    for (int s = 0; s < SLOTS; s++) begin
      m_rows[s]   = '0;
      m_values[s] = '0;
    end
    for (int p = 0; p < PARTS; p++) m_columns[p] = '0;
  endtask

  task automatic model_clear_tile();
    m_column  = '0;
    m_lane    = 0;
    m_part    = 0;
    m_started = 1'b0;
    m_image   = '0;
    model_clear_stores();
  endtask

  // Sweep the held image out as LANES*PARTS lane transactions.
  task automatic model_sweep_image();
    lane_t r;
    int    s;
    for (int p = 0; p < PARTS; p++) begin
      for (int l = 0; l < LANES; l++) begin
        s         = p * LANES + l;
        r.img     = m_image;
        r.part    = POS_W'(p);
        r.lane    = POS_W'(l);
        r.row     = m_rows[s];
        // unit mode: 1 for an occupied row, 0 for an empty one
        if (m_unit_mode) r.value = (m_rows[s] != '0) ? VAL_W'(1) : '0;
        else             r.value = m_values[s];
        r.col     = m_columns[p];
        r.col_ok  = (m_columns[p] != '0);
        r.is_last = (s == SLOTS - 1);
        lanes_due = {lanes_due, r};
      end
    end
    images_due++;
  endtask

  task automatic model_take_item(entry_t e);
    bit advance;
    int s;
    advance = 1'b0;
    if (e.kind == KIND_END_TILE) begin
      // end of tile always sweeps, even an empty image; fields are ignored
      model_sweep_image();
      model_clear_tile();
      return;
    end
    if (m_started) begin
      if (m_lane != 0 && m_column != e.col) begin
        advance = 1'b1;  // column changed inside a partly filled partition
        m_lane  = 0;
      end else if (m_lane == 0) begin
        advance = 1'b1;  // previous partition is full
      end
    end
    if (advance) begin
      m_part++;
      if (m_part >= PARTS) begin
        // entry spills past the last slot: the image before it goes out
        model_sweep_image();
        model_clear_stores();
        m_image = m_image + 1'b1;
        m_part  = 0;
      end
    end
    s              = m_part * LANES + m_lane;
    m_rows[s]      = e.row;
    m_values[s]    = e.value;
    m_columns[m_part] = e.col;
    m_column       = e.col;
    m_lane         = (m_lane + 1) % LANES;
    m_started      = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued entries, with random gap bursts.
  // The model is advanced on each accepted input transaction.
  // ---------------------------------------------------------------------------
  entry_t drv_cur;
  int     drv_gap;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      drv_gap     <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        model_take_item(drv_cur);
        items_sent++;
      end
      if (in_ch.valid && !in_ch.ready) begin
        in_stall_cycles++;  // hold the offer until it is taken
      end else if (drv_gap != 0) begin
        drv_gap     <= drv_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        drv_gap     <= $urandom_range(0, 18);
        in_ch.valid <= 1'b0;
      end else if (items_to_send.size() != 0) begin
        drv_cur            = items_to_send.pop_front();
        in_ch.valid        <= 1'b1;
        in_ch.kind         <= drv_cur.kind;
        in_ch.entry_row    <= drv_cur.row;
        in_ch.entry_column <= drv_cur.col;
        in_ch.entry_value  <= drv_cur.value;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Long receiver hold-off, counted here so the input queue backs up.
  // ---------------------------------------------------------------------------
  int  hold_cnt;
  bit  hold_done;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (hold_arm && !hold_done) begin
      hold_cnt  <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks every accepted lane transaction against the oldest
  // expectation and throttles ready in random stall bursts.
  // ---------------------------------------------------------------------------
  int rx_stall;

  task automatic show_lane(string tag, lane_t x);
    $display("  %s img=%0d part=%0d lane=%0d row=%h value=%h col=%h col_ok=%b last=%b",
             tag, x.img, x.part, x.lane, x.row, x.value, x.col, x.col_ok, x.is_last);
  endtask

  task automatic check_lane_out();
    lane_t got;
    lane_t want;
    got.img     = out_ch.image_number;
    got.part    = out_ch.partition_slot;
    got.lane    = out_ch.lane;
    got.row     = out_ch.slot_row;
    got.value   = out_ch.slot_value;
    got.col     = out_ch.slot_column;
    got.col_ok  = out_ch.column_valid;
    got.is_last = out_ch.last;
    lanes_seen++;
    if (lanes_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("[%0t] lane transaction with nothing expected", $realtime);
        show_lane("actual:  ", got);
      end
    end else begin
      want = lanes_due.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] lane transaction mismatch", $realtime);
          show_lane("expected:", want);
          show_lane("actual:  ", got);
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      rx_stall     <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_lane_out();
      if (rx_stall != 0) begin
        rx_stall     <= rx_stall - 1;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        rx_stall     <= $urandom_range(0, 18);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= (hold_cnt == 0);
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[%0t] timeout, %0d lane transactions still expected",
               $realtime, lanes_due.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer helpers
  // ---------------------------------------------------------------------------
  task automatic queue_item(logic kind, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                            logic [VAL_W-1:0] value);
    entry_t e;
    e.kind  = kind;
    e.row   = row;
    e.col   = col;
    e.value = value;
    if (kind == KIND_END_TILE) tiles_sent++;
    items_queued++;
    items_to_send = {items_to_send, e};
  endtask

  // Wait until the block has drained: every queued item accepted, nothing
  // expected, plus a short margin for entries still being written.
  task automatic wait_drained();
    while (items_sent != items_queued || lanes_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_unit_mode(bit on);
    @(posedge clk_i);
    cfg_ch.valid             <= 1'b1;
    cfg_ch.force_unit_values <= on;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    m_unit_mode  = on;
    mode_writes[on]++;
  endtask

  // Column-sorted tiles with random content: runs of one column, short runs
  // mostly, long ones now and then to overflow partitions. A few items are
  // noise (anything, end-of-tile included). Each tile closes with end of tile.
  task automatic queue_tiles(int n);
    int               left;
    int               tile_len;
    int               k;
    int               run;
    logic [COL_W-1:0] col;
    left = n;
    while (left > 0) begin
      tile_len = $urandom_range(4, 60);
      if (tile_len > left - 1) tile_len = left - 1;
      case ($urandom_range(0, 3))
        0:       col = $urandom_range(1, 50);
        1:       col = 32'hFFFF_FF00 + $urandom_range(0, 200);
        default: col = $urandom;
      endcase
      k = 0;
      while (k < tile_len) begin
        if ($urandom_range(0, 9) == 0) begin
          queue_item(1'($urandom_range(0, 1)), $urandom, $urandom,
                     VAL_W'($urandom_range(0, 65535)));
          k++;
        end else begin
          run = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(5, 20);
          for (int r = 0; r < run && k < tile_len; r++) begin
            queue_item(KIND_ENTRY, ($urandom_range(0, 15) == 0) ? '0 : $urandom, col,
                       VAL_W'($urandom_range(0, 65535)));
            k++;
          end
          col = col + $urandom_range(1, 3);
        end
      end
      queue_item(KIND_END_TILE, $urandom, $urandom, VAL_W'($urandom_range(0, 65535)));
      left -= tile_len + 1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_ch.valid              = 1'b0;
    in_ch.kind               = KIND_ENTRY;
    in_ch.entry_row          = '0;
    in_ch.entry_column       = '0;
    in_ch.entry_value        = '0;
    out_ch.ready             = 1'b0;
    cfg_ch.valid             = 1'b0;
    cfg_ch.force_unit_values = 1'b1;
    calm                     = 1'b0;
    hold_arm                 = 1'b0;
    mismatches               = 0;
    items_queued             = 0;
    items_sent               = 0;
    tiles_sent               = 0;
    lanes_seen               = 0;
    images_due               = 0;
    in_stall_cycles          = 0;
    mode_writes[0]           = 0;
    mode_writes[1]           = 0;
    m_unit_mode              = 1'b1;  // register resets to unit mode
    model_clear_tile();
    rst_ni                   = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: end of tile with nothing packed, once with all-ones fields
    // that must be ignored. Reset mode (unit values) is in force.
    queue_item(KIND_END_TILE, '0, '0, '0);
    queue_item(KIND_END_TILE, '1, '1, '1);
    wait_drained();

    // Directed, stored values: extremes, empty row, column zero, a full
    // partition, a partition opened by fill, and an entry that spills past
    // the last slot and pushes the image out.
    write_unit_mode(1'b0);
    queue_item(KIND_ENTRY, '1, 32'd1, '1);
    queue_item(KIND_ENTRY, '0, 32'd1, 16'h1234);
    queue_item(KIND_ENTRY, 32'd5, 32'd1, '0);
    queue_item(KIND_ENTRY, 32'd7, 32'd2, 16'd8);
    queue_item(KIND_ENTRY, 32'd3, '0, 16'd9);
    queue_item(KIND_ENTRY, 32'd9, '1, 16'h7FFF);
    for (int i = 0; i < LANES + 1; i++)
      queue_item(KIND_ENTRY, 32'd10 + i, 32'd3, VAL_W'($urandom_range(0, 65535)));
    queue_item(KIND_ENTRY, 32'd20, 32'd4, 16'd1);
    queue_item(KIND_ENTRY, 32'd21, 32'd5, 16'd2);
    queue_item(KIND_ENTRY, 32'd22, 32'd6, 16'd3);
    queue_item(KIND_END_TILE, '1, '1, '1);

    // Random phases, mode alternating. Phase 3 holds the receiver off while
    // the sender keeps going; the last phase runs without idling.
    for (int ph = 0; ph < 7; ph++) begin
      wait_drained();
      write_unit_mode(ph % 2 == 0);
      if (ph == 3) hold_arm <= 1'b1;
      if (ph == 6) calm <= 1'b1;
      queue_tiles(40);
    end

    wait_drained();
    repeat (20) @(posedge clk_i);

    $display("Run covered %0d input transactions in %0d tiles, %0d lane transactions",
             items_sent, tiles_sent, lanes_seen);
    $display("over %0d images; unit mode on %0d / off %0d writes; %0d input stall cycles",
             images_due, mode_writes[1], mode_writes[0], in_stall_cycles);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
rtl/core/scpp_pkg.sv
rtl/core/scpp_if.sv
rtl/core/scpp_front.sv
rtl/core/scpp_queue.sv
rtl/core/scpp_back.sv
rtl/core/sparse_column_partition_packer.sv
tb/tb.sv
